[sv/treb_pkg.sv]
// ----------------------------------------------------------------------------
// treb_pkg
// Types, widths and word tags shared by the TDC readout event builder.
// ----------------------------------------------------------------------------
package treb_pkg;

    localparam int CHANNELS_DEF = 32;
    localparam int HITS_DEF     = 1024;

    localparam int WORD_W  = 32;
    localparam int TAG_W   = 5;
    localparam int CH_W    = 5;
    localparam int RAW_W   = 21;
    localparam int EVT_W   = 22;
    localparam int CNT_W   = 11;
    localparam int WCNT_W  = 16;
    localparam int TTAG_W  = 27;
    localparam int TLOW_W  = 5;
    localparam int STAMP_W = 32;

    // word tags, bits 31..27 after optional byte swap
    localparam logic [TAG_W-1:0] TAG_HIT  = 5'h00;
    localparam logic [TAG_W-1:0] TAG_GHDR = 5'h08;
    localparam logic [TAG_W-1:0] TAG_GTRL = 5'h10;
    localparam logic [TAG_W-1:0] TAG_TTAG = 5'h11;

    typedef enum logic [1:0] {
        K_HIT   = 2'd0,
        K_COUNT = 2'd1,
        K_EVENT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              trailing;
        logic [CH_W-1:0]   channel;
        logic [RAW_W-1:0]  raw_time;
        logic [EVT_W-1:0]  event_number;
        logic [TTAG_W-1:0] trig_high;
        logic [WCNT_W-1:0] word_total;
        logic [TLOW_W-1:0] trig_low;
    } t_dec;

    typedef struct packed {
        t_kind              kind;
        logic [CH_W-1:0]    channel;
        logic               trailing;
        logic [RAW_W-1:0]   raw_time;
        logic [EVT_W-1:0]   event_number;
        logic [CNT_W-1:0]   leading_hits;
        logic [CNT_W-1:0]   trailing_hits;
        logic [WCNT_W-1:0]  word_total;
        logic [STAMP_W-1:0] trigger_stamp;
        logic               trigger_seen;
        logic               any_leading;
        logic               last;
    } t_rec;

endpackage

[sv/treb_ifs.sv]
// ----------------------------------------------------------------------------
// treb_in_if / treb_out_if
// Valid/ready channels for readout words and result records.
// ----------------------------------------------------------------------------
interface treb_in_if;
    import treb_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface treb_out_if;
    import treb_pkg::*;
    logic valid;
    logic ready;
    t_rec rec;
    modport source (output valid, output rec, input ready);
    modport sink   (input valid, input rec, output ready);
endinterface

[sv/tdc_readout_event_builder_top.sv]
// ----------------------------------------------------------------------------
// tdc_readout_event_builder_top
// Multi-hit TDC readout decoder with per-channel hit counting in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries 32-bit readout words (valid/ready, a transaction per word).
//   o_out carries result records; o_out.rec.last marks the final record of
//   the word that caused it. i_cfg_wr_en/i_cfg_wr_data write byte_swap;
//   write it only while the block is idle.
// Sequence:
//   Header, trigger tag and unused words are taken in idle and give no record.
//   A measurement word: accept/RAM read, then (state S_HIT) RAM
//   read-modify-write of the channel counters and loading of the hit record
//   into the output register, which drives the record valid.
//   A trailer: one count record per cycle while the output is ready, swept
//   out of the counter RAM (each entry written back as zero behind the read),
//   then the event record. The single RAM port pair sets this sequence.
// Reset (synchronous, active low): counters read as zero through per-entry
//   valid bits, event number and trigger time cleared, byte_swap off.
// Stall: a held output stops the hit write-back and the trailer sweep;
//   i_in.ready is low until the current word's records are all loaded.
// ----------------------------------------------------------------------------
module tdc_readout_event_builder_top #(
    parameter int CHANNELS         = treb_pkg::CHANNELS_DEF,
    parameter int HITS_PER_CHANNEL = treb_pkg::HITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    treb_in_if.sink      i_in,
    treb_out_if.source   o_out
);
    import treb_pkg::*;

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_W = 2 * CNT_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HIT,
        S_DUMP,
        S_EVENT
    } t_state;

    // control state
    t_state              r_state,     n_state;
    logic                r_out_valid, n_out_valid;
    logic                r_byte_swap, n_byte_swap;
    logic [CHANNELS-1:0] r_vld,       n_vld;
    logic                r_rd_vld,    n_rd_vld;
    logic [EVT_W-1:0]    r_event,     n_event;
    logic [STAMP_W-1:0]  r_trig,      n_trig;
    logic                r_any,       n_any;
    logic [AW-1:0]       r_idx,       n_idx;
    // payload
    t_rec                r_out_rec,   n_out_rec;
    logic [AW-1:0]       r_hch,       n_hch;
    logic                r_htr,       n_htr;
    logic [RAW_W-1:0]    r_hraw,      n_hraw;
    logic [WCNT_W-1:0]   r_words,     n_words;

    t_dec             dec;
    logic             accept;
    logic             can_load;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [RAM_W-1:0] ram_rdata;
    logic [CNT_W-1:0] rd_lead;
    logic [CNT_W-1:0] rd_trail;
    logic [CNT_W:0]   rd_sum;

    treb_decode u_decode (
        .i_word      (i_in.data_word),
        .i_byte_swap (r_byte_swap),
        .o_dec       (dec)
    );

    treb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign can_load    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.rec   = r_out_rec;

    // never-written entries read as zero
    assign rd_lead  = r_rd_vld ? ram_rdata[RAM_W-1:CNT_W] : '0;
    assign rd_trail = r_rd_vld ? ram_rdata[CNT_W-1:0]     : '0;
    assign rd_sum   = {1'b0, rd_lead} + {1'b0, rd_trail};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_rec   = r_out_rec;
        n_byte_swap = i_cfg_wr_en ? i_cfg_wr_data : r_byte_swap;
        n_vld       = r_vld;
        n_rd_vld    = r_rd_vld;
        n_event     = r_event;
        n_trig      = r_trig;
        n_any       = r_any;
        n_idx       = r_idx;
        n_hch       = r_hch;
        n_htr       = r_htr;
        n_hraw      = r_hraw;
        n_words     = r_words;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (dec.tag)
                        TAG_HIT: begin
                            // channels beyond the configured count are dropped
                            if ({1'b0, dec.channel} < 6'(CHANNELS)) begin
                                ram_re    = 1'b1;
                                ram_raddr = dec.channel[AW-1:0];
                                n_rd_vld  = r_vld[dec.channel[AW-1:0]];
                                n_hch     = dec.channel[AW-1:0];
                                n_htr     = dec.trailing;
                                n_hraw    = dec.raw_time;
                                n_state   = S_HIT;
                            end
                        end
                        TAG_GHDR: begin
                            n_event = dec.event_number;
                        end
                        TAG_TTAG: begin
                            n_trig = {dec.trig_high, {TLOW_W{1'b0}}};
                        end
                        TAG_GTRL: begin
                            n_trig    = r_trig | {{(STAMP_W-TLOW_W){1'b0}}, dec.trig_low};
                            n_words   = dec.word_total;
                            n_any     = 1'b0;
                            n_idx     = '0;
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_rd_vld  = r_vld[0];
                            n_state   = S_DUMP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HIT: begin
                if (can_load) begin
                    n_state = S_IDLE;
                    // channel full: drop silently
                    if (rd_sum < 12'(HITS_PER_CHANNEL)) begin
                        ram_we        = 1'b1;
                        ram_waddr     = r_hch;
                        ram_wdata     = r_htr ? {rd_lead, rd_trail + 1'b1}
                                              : {rd_lead + 1'b1, rd_trail};
                        n_vld[r_hch]  = 1'b1;
                        n_out_valid   = 1'b1;
                        n_out_rec              = '0;
                        n_out_rec.kind         = K_HIT;
                        n_out_rec.channel      = CH_W'(r_hch);
                        n_out_rec.trailing     = r_htr;
                        n_out_rec.raw_time     = r_hraw;
                        n_out_rec.event_number = r_event;
                        n_out_rec.last         = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                if (can_load) begin
                    n_out_valid             = 1'b1;
                    n_out_rec               = '0;
                    n_out_rec.kind          = K_COUNT;
                    n_out_rec.channel       = CH_W'(r_idx);
                    n_out_rec.event_number  = r_event;
                    n_out_rec.leading_hits  = rd_lead;
                    n_out_rec.trailing_hits = rd_trail;
                    // clear entry behind the read
                    ram_we       = 1'b1;
                    ram_waddr    = r_idx;
                    ram_wdata    = '0;
                    n_vld[r_idx] = 1'b0;
                    n_any        = r_any || (rd_lead != '0);
                    if (r_idx == LAST_IDX) begin
                        n_state = S_EVENT;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + 1'b1;
                        n_rd_vld  = r_vld[r_idx + 1'b1];
                    end
                end
            end
            S_EVENT: begin
                if (can_load) begin
                    n_out_valid             = 1'b1;
                    n_out_rec               = '0;
                    n_out_rec.kind          = K_EVENT;
                    n_out_rec.event_number  = r_event;
                    n_out_rec.word_total    = r_words;
                    n_out_rec.trigger_stamp = r_trig;
                    n_out_rec.trigger_seen  = (r_trig != '0);
                    n_out_rec.any_leading   = r_any;
                    n_out_rec.last          = 1'b1;
                    n_event = '0;
                    n_trig  = '0;
                    n_any   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_rec <= n_out_rec;
        r_hch     <= n_hch;
        r_htr     <= n_htr;
        r_hraw    <= n_hraw;
        r_words   <= n_words;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_byte_swap <= 1'b0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_event     <= '0;
            r_trig      <= '0;
            r_any       <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_byte_swap <= n_byte_swap;
            r_vld       <= n_vld;
            r_rd_vld    <= n_rd_vld;
            r_event     <= n_event;
            r_trig      <= n_trig;
            r_any       <= n_any;
            r_idx       <= n_idx;
        end
    end

`ifndef NO_ASSERTIONS
    // read and write never target the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("counter RAM read/write collision");

    // event record only follows the count sweep
    a_event_after_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVENT && $past(r_state) != S_EVENT) |-> $past(r_state) == S_DUMP)
        else $error("event state entered without count sweep");

    // trailer leaves event state cleared
    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVENT && can_load) |=>
            (r_state == S_IDLE && r_event == '0 && r_trig == '0 && !r_any))
        else $error("event state not cleared after event record");

    // sweep clears valid bits of all entries visited
    a_sweep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && can_load) |=> !r_vld[$past(r_idx)])
        else $error("swept counter entry still valid");
`endif
endmodule

[sv/treb_ram.sv]
// ----------------------------------------------------------------------------
// treb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module treb_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/treb_decode.sv]
// ----------------------------------------------------------------------------
// treb_decode
// Optional byte reversal and field extraction of one readout word.
// ----------------------------------------------------------------------------
module treb_decode (
    input  logic [treb_pkg::WORD_W-1:0] i_word,
    input  logic                        i_byte_swap,
    output treb_pkg::t_dec              o_dec
);
    import treb_pkg::*;

    logic [WORD_W-1:0] w;

    assign w = i_byte_swap ? {i_word[7:0], i_word[15:8], i_word[23:16], i_word[31:24]}
                           : i_word;

    always_comb begin
        o_dec.tag          = w[31:27];
        o_dec.trailing     = w[26];
        o_dec.channel      = w[25:21];
        o_dec.raw_time     = w[20:0];
        o_dec.event_number = w[26:5];
        o_dec.trig_high    = w[26:0];
        o_dec.word_total   = w[20:5];
        o_dec.trig_low     = w[4:0];
    end
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TDC readout event builder. A directed table
// walks the tag types, field extremes and trigger/trailer corner cases, then
// random events follow under both byte orders. Every record is checked field
// by field against a predictor kept inside the bench, while both handshakes
// idle at random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import treb_pkg::*;

    // Config writes wait this long after the last record, to cover a trailer
    // sweep or a no-record word still inside the block.
    localparam int SETTLE_CYC = CHANNELS_DEF + 8;
    // Long receiver hold-off, enough to back the block up into its input.
    localparam int HOLD_CYC   = 300;
    localparam int RAND_WORDS = 55;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    treb_in_if  word_ch ();
    treb_out_if rec_ch ();

    tdc_readout_event_builder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (word_ch.sink),
        .o_out         (rec_ch.source)
    );

    // ------------------------------------------------------------------------
    // Predictor state: per-channel edge counters, event number, trigger time
    // and the byte order in force. Mirrors the block's architectural state.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]   lead_cnt  [CHANNELS_DEF];
    logic [CNT_W-1:0]   trail_cnt [CHANNELS_DEF];
    logic [EVT_W-1:0]   evt_num;
    logic [STAMP_W-1:0] trig_time;
    logic               swap_on;

    // records predicted but not yet seen on the output, oldest first
    t_rec pending_recs[$];

    // bookkeeping for the summary and the verdict
    int words_in, swapped_words, useful_words, recs_out, events_closed, hits_capped;
    int mismatch_count, stray_count, report_count;
    int hold_cycles;
    int send_calm, recv_calm;

    // directed table: raw word, plus a hand-written record where the answer
    // is obvious (hit records right after reset, at field extremes or after a known header)
    typedef struct {
        logic [WORD_W-1:0] word;
        bit                typed;
        t_rec              rec;
    } t_dir_row;

    t_dir_row dir_rows[$];

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] flip_bytes(logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic t_rec hit_rec(logic [CH_W-1:0] ch, logic tr,
                                     logic [RAW_W-1:0] raw, logic [EVT_W-1:0] ev);
        t_rec r;
        r              = '0;
        r.kind         = K_HIT;
        r.channel      = ch;
        r.trailing     = tr;
        r.raw_time     = raw;
        r.event_number = ev;
        r.last         = 1'b1;
        return r;
    endfunction

    // append one predicted record at the tail
    function automatic void enqueue_rec(t_rec r);
        pending_recs = {pending_recs, r};
    endfunction

    // Gap length for either side: mostly none or short, now and then long,
    // and occasional calm runs with no idling at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: decodes one accepted raw word, updates the state and queues
    // the records it causes. Returns how many it queued.
    // ------------------------------------------------------------------------
    function automatic int predict_records(logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] w;
        logic [CH_W-1:0]   ch;
        logic              any_lead;
        t_rec              r;
        w  = swap_on ? flip_bytes(raw) : raw;
        ch = w[25:21];
        if (w[31:27] == TAG_HIT) begin
            // channel already at the cap: the hit is dropped silently
            if (int'(lead_cnt[ch]) + int'(trail_cnt[ch]) >= HITS_DEF) begin
                hits_capped++;
                return 0;
            end
            if (w[26]) trail_cnt[ch]++;
            else       lead_cnt[ch]++;
            enqueue_rec(hit_rec(ch, w[26], w[20:0], evt_num));
            return 1;
        end
        if (w[31:27] == TAG_GHDR) begin
            evt_num = w[26:5];
            return 0;
        end
        if (w[31:27] == TAG_TTAG) begin
            // low trigger bits are cleared here and filled by the trailer
            trig_time = {w[26:0], 5'b0};
            return 0;
        end
        if (w[31:27] == TAG_GTRL) begin
            trig_time = trig_time | {27'b0, w[4:0]};
            any_lead  = 1'b0;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                r               = '0;
                r.kind          = K_COUNT;
                r.channel       = CH_W'(c);
                r.event_number  = evt_num;
                r.leading_hits  = lead_cnt[c];
                r.trailing_hits = trail_cnt[c];
                if (lead_cnt[c] != '0) any_lead = 1'b1;
                enqueue_rec(r);
            end
            r               = '0;
            r.kind          = K_EVENT;
            r.event_number  = evt_num;
            r.word_total    = w[20:5];
            r.trigger_stamp = trig_time;
            r.trigger_seen  = (trig_time != '0);
            r.any_leading   = any_lead;
            r.last          = 1'b1;
            enqueue_rec(r);
            // event closed: everything but the byte order goes back to zero
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                lead_cnt[c]  = '0;
                trail_cnt[c] = '0;
            end
            evt_num   = '0;
            trig_time = '0;
            events_closed++;
            return CHANNELS_DEF + 1;
        end
        // any other tag is ignored by the block
        return 0;
    endfunction

    // Field-by-field comparison; returns the differing fields as text.
    function automatic string rec_diff(t_rec got, t_rec want);
        string s;
        s = "";
        if (got.kind !== want.kind)
            s = {s, $sformatf(" kind %0d/%0d", want.kind, got.kind)};
        if (got.channel !== want.channel)
            s = {s, $sformatf(" channel %0d/%0d", want.channel, got.channel)};
        if (got.trailing !== want.trailing)
            s = {s, $sformatf(" trailing %0b/%0b", want.trailing, got.trailing)};
        if (got.raw_time !== want.raw_time)
            s = {s, $sformatf(" raw_time %h/%h", want.raw_time, got.raw_time)};
        if (got.event_number !== want.event_number)
            s = {s, $sformatf(" event_number %h/%h", want.event_number, got.event_number)};
        if (got.leading_hits !== want.leading_hits)
            s = {s, $sformatf(" leading_hits %0d/%0d", want.leading_hits, got.leading_hits)};
        if (got.trailing_hits !== want.trailing_hits)
            s = {s, $sformatf(" trailing_hits %0d/%0d", want.trailing_hits,
                              got.trailing_hits)};
        if (got.word_total !== want.word_total)
            s = {s, $sformatf(" word_total %h/%h", want.word_total, got.word_total)};
        if (got.trigger_stamp !== want.trigger_stamp)
            s = {s, $sformatf(" trigger_stamp %h/%h", want.trigger_stamp,
                              got.trigger_stamp)};
        if (got.trigger_seen !== want.trigger_seen)
            s = {s, $sformatf(" trigger_seen %0b/%0b", want.trigger_seen, got.trigger_seen)};
        if (got.any_leading !== want.any_leading)
            s = {s, $sformatf(" any_leading %0b/%0b", want.any_leading, got.any_leading)};
        if (got.last !== want.last)
            s = {s, $sformatf(" last %0b/%0b", want.last, got.last)};
        return s;
    endfunction

    function automatic void add_row(logic [WORD_W-1:0] w, bit typed, t_rec r);
        t_dir_row row;
        row.word  = w;
        row.typed = typed;
        row.rec   = r;
        dir_rows  = {dir_rows, row};
    endfunction

    function automatic logic [WORD_W-1:0] unused_word();
        logic [TAG_W-1:0] t;
        do t = 5'($urandom_range(1, 31));
        while (t == TAG_GHDR || t == TAG_GTRL || t == TAG_TTAG);
        return {t, 27'($urandom)};
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Input side. Drive at the falling edge, take the transaction at the
    // rising edge where ready is high, and predict at that same edge. Valid
    // stays high back to back when there is no gap, so it only ever gets
    // one assignment per step.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [WORD_W-1:0] raw, bit typed, t_rec typed_rec);
        int gap;
        int n;
        gap = pick_gap(send_calm);
        @(negedge i_clk);
        if (gap != 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.data_word <= raw;
        do @(posedge i_clk); while (word_ch.ready !== 1'b1);
        words_in++;
        if (swap_on) swapped_words++;
        n = predict_records(raw);
        // hand-written row: it stands in for the predicted hit record
        if (typed && n == 1)
            pending_recs[pending_recs.size() - 1] = typed_rec;
    endtask

    // Send a word given in decoded byte order; swapped on the wire when the
    // block is set to reverse bytes. Ignored tags do not count as useful.
    task automatic emit(logic [WORD_W-1:0] w);
        if (w[31:27] inside {TAG_HIT, TAG_GHDR, TAG_GTRL, TAG_TTAG})
            useful_words++;
        send_word(swap_on ? flip_bytes(w) : w, 1'b0, '0);
    endtask

    // byte_swap write: only with the input idle and every record drained,
    // plus a settle time for words still inside the block
    task automatic set_swap(logic b);
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
        while (pending_recs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= b;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        swap_on = b;
    endtask

    // One well-formed event with random content, with ignored words mixed in.
    // Sometimes channels are squeezed to a few so the counters climb.
    task automatic random_event();
        int n_hits;
        int ch_top;
        emit({TAG_GHDR, 27'($urandom)});
        if ($urandom_range(0, 9) < 7) emit({TAG_TTAG, 27'($urandom)});
        n_hits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        ch_top = $urandom_range(0, 1) ? 3 : 31;
        for (int i = 0; i < n_hits; i++) begin
            if ($urandom_range(0, 9) == 0) emit(unused_word());
            emit({TAG_HIT, 1'($urandom), 5'($urandom_range(0, ch_top)), 21'($urandom)});
        end
        emit({TAG_GTRL, 27'($urandom)});
    endtask

    // Broken sequences: hits with no header, an event left open, or a
    // trailer that closes nothing.
    task automatic broken_sequence();
        case ($urandom_range(0, 2))
            0: begin
                repeat ($urandom_range(1, 4))
                    emit({TAG_HIT, 1'($urandom), 5'($urandom), 21'($urandom)});
                emit({TAG_GTRL, 27'($urandom)});
            end
            1: begin
                emit({TAG_GHDR, 27'($urandom)});
                repeat ($urandom_range(1, 3))
                    emit({TAG_HIT, 1'($urandom), 5'($urandom), 21'($urandom)});
            end
            default: begin
                emit({TAG_TTAG, 27'($urandom)});
                emit({TAG_GTRL, 27'($urandom)});
                emit({TAG_GTRL, 27'($urandom)});
            end
        endcase
    endtask

    task automatic random_phase(int n_words);
        int start;
        int pick;
        start = useful_words;
        while (useful_words - start < n_words) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)       random_event();
            else if (pick == 7) broken_sequence();
            else                emit($urandom);   // raw noise, any tag
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side. Ready toggles at the falling edge; a requested hold-off
    // keeps it low for a long stretch while the sender keeps offering words.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        rec_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                rec_ch.ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
                rec_ch.ready <= 1'b1;
            end else begin
                stall = pick_gap(recv_calm);
                if (stall != 0) begin
                    rec_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                rec_ch.ready <= 1'b1;
            end
        end
    end

    // Record checker: every output transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_rec  want;
        string d;
        if (i_rst_n && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
            recs_out++;
            if (pending_recs.size() == 0) begin
                stray_count++;
                if (report_count < 10)
                    $display("unexpected record %0d at %0t: kind %0d channel %0d",
                             recs_out, $realtime, rec_ch.rec.kind, rec_ch.rec.channel);
                report_count++;
            end else begin
                want = pending_recs.pop_front();
                d    = rec_diff(rec_ch.rec, want);
                if (d != "") begin
                    mismatch_count++;
                    if (report_count < 10)
                        $display("record %0d mismatch at %0t (expected/actual):%s",
                                 recs_out, $realtime, d);
                    report_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        word_ch.valid     = 1'b0;
        word_ch.data_word = '0;
        swap_on           = 1'b0;
        evt_num           = '0;
        trig_time         = '0;
        hold_cycles       = 0;
        send_calm         = 0;
        recv_calm         = 0;
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            lead_cnt[c]  = '0;
            trail_cnt[c] = '0;
        end

        // Directed table. Hit rows right after reset, at field extremes or after a
        // known header carry their record by hand; the rest go through the predictor.
        add_row(32'h0000_0000, 1, hit_rec(5'd0, 1'b0, 21'h0, 22'h0));           // hit, all zero
        add_row(32'h07FF_FFFF, 1, hit_rec(5'd31, 1'b1, 21'h1F_FFFF, 22'h0));    // hit, all ones
        add_row(32'h8000_0000, 0, '0);  // trailer, no trigger, zero word count
        add_row(32'h47FF_FFE0, 0, '0);  // header, largest event number
        add_row(32'h0001_2345, 1, hit_rec(5'd0, 1'b0, 21'h1_2345, 22'h3F_FFFF));
        add_row(32'h8FFF_FFFF, 0, '0);  // trigger tag, all high bits set
        add_row(32'hC000_0000, 0, '0);  // ignored tags, several kinds
        add_row(32'hF800_0000, 0, '0);
        add_row(32'h0800_0000, 0, '0);
        add_row(32'h97FF_FFFF, 0, '0);
        add_row(32'h87FF_FFFF, 0, '0);  // trailer: full word count, stamp all ones
        add_row(32'h4000_00A0, 0, '0);  // header, event 5
        add_row(32'h8800_0001, 0, '0);  // trigger tag, low bits start clear
        add_row(32'h04E0_0055, 1, hit_rec(5'd7, 1'b1, 21'h55, 22'd5));         // trailing only
        add_row(32'h8000_0000, 0, '0);  // trailer: trigger seen, no leading edge
        add_row(32'h8000_0000, 0, '0);  // trailer on cleared state
        add_row(32'h8800_0000, 0, '0);  // trigger tag of zero
        add_row(32'h8000_0001, 0, '0);  // trailer supplies only the low bits

        // Reset: held low at the start, released once.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_swap(1'b0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].rec);

        // Random events, swapped byte order first, with the long hold-off
        // landing while the sender keeps pushing.
        set_swap(1'b1);
        hold_cycles = HOLD_CYC;
        random_phase(RAND_WORDS);
        set_swap(1'b0);
        random_phase(RAND_WORDS);
        set_swap(1'b1);
        random_phase(RAND_WORDS);

        // Drain: everything predicted must come out, then a quiet tail.
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
        while (pending_recs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Covered %0d readout words (%0d byte-swapped), %0d records over %0d events.",
                 words_in, swapped_words, recs_out, events_closed);
        $display("Hits dropped at the channel cap: %0d; mismatches %0d, unexpected records %0d.",
                 hits_capped, mismatch_count, stray_count);
        if (mismatch_count == 0 && stray_count == 0 && pending_recs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
